/* hw/rtl/laers_pkg.sv */
package laers_pkg;

  // Command codes carried in tuser of the input stream.
  localparam logic [1:0] CMD_LOSS = 2'd0;
  localparam logic [1:0] CMD_RTX  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;
  localparam logic [1:0] CMD_BW   = 2'd3;

  // Field widths of the streams.
  localparam int LOSS_W = 7;
  localparam int RTX_W  = 16;
  localparam int BW_W   = 20;
  localparam int PROT_W = 6;
  localparam int ENC_W  = 20;
  localparam int ACC_W  = 32;
  localparam int KBPS_W = 26;
  localparam int PROD_W = 27;

  // Fixed arithmetic constants.
  localparam int PCT_SCALE    = 100;
  localparam int PROT_CAP     = 50;
  localparam int AVG_CAP      = 25;

  // Reciprocals for the two fixed divisions. Bytes * 8 / 1000 equals bytes / 125, taken
  // as (bytes * TICK_RECIP) >> TICK_SHIFT, exact for every 32-bit count. The percentage
  // scaling is (product * PCT_RECIP) >> PCT_SHIFT, exact for every product below 2**27.
  localparam int TICK_RECIP_W = 32;
  localparam int TICK_SHIFT   = 38;
  localparam logic [TICK_RECIP_W-1:0] TICK_RECIP = 32'h83126E98;
  localparam int PCT_RECIP_W  = 26;
  localparam int PCT_SHIFT    = 32;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 26'd42949673;

  // Serial divider for the window average.
  localparam int DIV_N_W  = 32;
  localparam int DIV_D_W  = 9;
  localparam int NBITS_W  = 6;

  typedef logic [DIV_N_W-1:0] div_num_t;
  typedef logic [DIV_D_W-1:0] div_den_t;
  typedef logic [NBITS_W-1:0] div_nbits_t;

  typedef struct packed {
    logic       start;
    div_num_t   num;
    div_den_t   den;
    div_nbits_t nbits;
  } div_req_t;

  typedef struct packed {
    logic     done;
    div_num_t quot;
  } div_rsp_t;

endpackage

/* hw/rtl/laers_ram.sv */
module laers_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/laers_div.sv */
module laers_div (
  input  logic                clk,
  input  logic                rst,
  input  laers_pkg::div_req_t req,
  output laers_pkg::div_rsp_t rsp
);

  // Restoring divider, one quotient bit per cycle. The dividend is aligned to
  // the top of the shift register so that only nbits steps are needed.
  logic                         busy;
  logic                         done;
  logic [laers_pkg::NBITS_W-1:0] left;
  laers_pkg::div_num_t          quo;
  laers_pkg::div_den_t          rem;
  laers_pkg::div_den_t          den;
  logic [laers_pkg::DIV_D_W:0]  trial;
  logic                         ge;
  logic [laers_pkg::NBITS_W-1:0] align;

  assign trial = {rem, quo[laers_pkg::DIV_N_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign align = laers_pkg::NBITS_W'(laers_pkg::DIV_N_W) - req.nbits;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        left <= req.nbits;
        quo  <= req.num << align;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        quo  <= {quo[laers_pkg::DIV_N_W-2:0], ge};
        rem  <= ge ? laers_pkg::div_den_t'(trial - {1'b0, den})
                   : trial[laers_pkg::DIV_D_W-1:0];
        left <= left - 1'b1;
        if (left == laers_pkg::NBITS_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

/* hw/rtl/loss_aware_encoder_rate_split.sv */
// Path from the accepting edge to a valid result: a bandwidth update with a non-empty window
// runs an 11-step serial average for a 16-entry window, then the multiply, the scaling, the
// output state and the output register; with an empty window it skips the average. A loss
// report holds the input through the window update; a retransmit byte report or a
// one-second tick does not. Throughput: one request at a time; a bandwidth update blocks
// the input until its result is loaded, and longer while an earlier result waits downstream.
// Reset is synchronous and active high; it clears pointer, count, sum, byte counter and
// rate. The loss window memory is not cleared and is read only where it was written.
module loss_aware_encoder_rate_split #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, from bit 0: loss_pct[6:0], rtx_bytes[15:0], bandwidth_kbps[19:0], zero fill
  input  logic [47:0] s_tdata,
  // s_tuser: command[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0: protection_pct[5:0], target_kbps[19:0], zero fill
  output logic [31:0] m_tdata
);

  // Widths that follow from the window depth.
  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = $clog2(127 * HISTORY_DEPTH + 1);

  // Widths of the reciprocal products.
  localparam int TICK_PROD_W = laers_pkg::ACC_W + laers_pkg::TICK_RECIP_W;
  localparam int ENC_PROD_W  = laers_pkg::PROD_W + laers_pkg::PCT_RECIP_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_LOSS_RD   = 3'd1;
  localparam logic [2:0] ST_PROT_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL       = 3'd3;
  localparam logic [2:0] ST_ENC_SCALE = 3'd4;
  localparam logic [2:0] ST_OUT       = 3'd5;

  logic [2:0] state;

  // Unpacked request fields.
  logic [1:0]                    in_cmd;
  logic [laers_pkg::LOSS_W-1:0]  in_loss;
  logic [laers_pkg::RTX_W-1:0]   in_rtx;
  logic [laers_pkg::BW_W-1:0]    in_bw;

  assign in_cmd  = s_tuser;
  assign in_loss = s_tdata[6:0];
  assign in_rtx  = s_tdata[22:7];
  assign in_bw   = s_tdata[42:23];

  logic accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Block state held in registers beside the window memory.
  logic [PTR_W-1:0]              wptr;
  logic [CNT_W-1:0]              count;
  logic [SUM_W-1:0]              sum;
  logic [laers_pkg::ACC_W-1:0]   acc;
  logic [laers_pkg::KBPS_W-1:0]  rtx_kbps;

  // Working registers of the request in flight.
  logic [laers_pkg::LOSS_W-1:0]  loss_r;
  logic [laers_pkg::BW_W-1:0]    bw_r;
  logic [laers_pkg::PROT_W-1:0]  prot_r;
  logic [laers_pkg::PROD_W-1:0]  prod_r;
  logic [laers_pkg::ENC_W-1:0]   enc_r;

  // Output register.
  logic                          out_valid;
  logic [laers_pkg::PROT_W-1:0]  out_prot;
  logic [laers_pkg::ENC_W-1:0]   out_enc;

  // Window memory: read at the write pointer when a loss report arrives, and the new
  // value written back to the same slot in the next cycle. Requests are handled one at a
  // time, so no two accesses to an entry overlap.
  logic                          win_we;
  logic [laers_pkg::LOSS_W-1:0]  win_rdata;

  laers_ram #(
    .WIDTH (laers_pkg::LOSS_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (win_we),
    .waddr (wptr),
    .wdata (loss_r),
    .raddr (wptr),
    .rdata (win_rdata)
  );

  assign win_we = (state == ST_LOSS_RD);

  logic             full;
  logic [SUM_W-1:0] sum_next;

  assign full     = (count == CNT_W'(HISTORY_DEPTH));
  assign sum_next = sum - (full ? SUM_W'(win_rdata) : '0) + SUM_W'(loss_r);

  // The serial divider forms the window average; the divisor is the entry count.
  laers_pkg::div_req_t div_req;
  laers_pkg::div_rsp_t div_rsp;

  laers_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    div_req.start = accept && (in_cmd == laers_pkg::CMD_BW) && (count != '0);
    div_req.num   = laers_pkg::div_num_t'(sum);
    div_req.den   = laers_pkg::div_den_t'(count);
    div_req.nbits = laers_pkg::div_nbits_t'(SUM_W);
  end

  // Protection is twice the average, held at the cap once the average passes half of it.
  logic [laers_pkg::PROT_W-1:0] prot_calc;
  assign prot_calc = (div_rsp.quot > laers_pkg::div_num_t'(laers_pkg::AVG_CAP))
                   ? laers_pkg::PROT_W'(laers_pkg::PROT_CAP)
                   : {div_rsp.quot[laers_pkg::PROT_W-2:0], 1'b0};

  // Bandwidth left after retransmissions, held at zero when they use it all.
  logic [laers_pkg::BW_W-1:0] diff;
  logic [6:0]                 share;
  assign diff  = (laers_pkg::KBPS_W'(bw_r) > rtx_kbps)
               ? laers_pkg::BW_W'(laers_pkg::KBPS_W'(bw_r) - rtx_kbps) : '0;
  assign share = 7'(laers_pkg::PCT_SCALE) - 7'(prot_r);

  // Fixed divisions by reciprocal multiplication: the byte counter over 125 at a tick,
  // and the scaled bandwidth over 100.
  logic [TICK_PROD_W-1:0] tick_prod;
  logic [ENC_PROD_W-1:0]  enc_prod;
  assign tick_prod = TICK_PROD_W'(acc) * TICK_PROD_W'(laers_pkg::TICK_RECIP);
  assign enc_prod  = ENC_PROD_W'(prod_r) * ENC_PROD_W'(laers_pkg::PCT_RECIP);

  // Saturating byte counter.
  logic [laers_pkg::ACC_W:0] acc_sum;
  assign acc_sum = {1'b0, acc} + (laers_pkg::ACC_W + 1)'(in_rtx);

  logic out_free;
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wptr     <= '0;
      count    <= '0;
      sum      <= '0;
      acc      <= '0;
      rtx_kbps <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            loss_r <= in_loss;
            bw_r   <= in_bw;
            case (in_cmd)
              laers_pkg::CMD_LOSS: begin
                state <= ST_LOSS_RD;
              end
              laers_pkg::CMD_RTX: begin
                acc <= acc_sum[laers_pkg::ACC_W] ? '1 : acc_sum[laers_pkg::ACC_W-1:0];
              end
              laers_pkg::CMD_TICK: begin
                rtx_kbps <= tick_prod[laers_pkg::TICK_SHIFT +: laers_pkg::KBPS_W];
                acc      <= '0;
              end
              laers_pkg::CMD_BW: begin
                if (count == '0) begin
                  prot_r <= '0;
                  state  <= ST_MUL;
                end else begin
                  state <= ST_PROT_DIV;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_LOSS_RD: begin
          sum   <= sum_next;
          wptr  <= (wptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wptr + 1'b1;
          if (!full) begin
            count <= count + 1'b1;
          end
          state <= ST_IDLE;
        end
        ST_PROT_DIV: begin
          if (div_rsp.done) begin
            prot_r <= prot_calc;
            state  <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r <= laers_pkg::PROD_W'(diff) * laers_pkg::PROD_W'(share);
          state  <= ST_ENC_SCALE;
        end
        ST_ENC_SCALE: begin
          enc_r <= enc_prod[laers_pkg::PCT_SHIFT +: laers_pkg::ENC_W];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The result waits here for the downstream side while new requests are taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_OUT) && out_free) begin
      out_valid <= 1'b1;
      out_prot  <= prot_r;
      out_enc   <= enc_r;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_enc, out_prot};

endmodule

/* verif/laers_checker.sv */
`timescale 1ns / 1ps

module laers_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen
);

  localparam int HIST_DEPTH = 16;

  typedef struct packed {
    logic [laers_pkg::PROT_W-1:0] protection_pct;
    logic [laers_pkg::ENC_W-1:0]  target_kbps;
  } split_t;

  // Shadow of the block's loss window, byte counter and last tick rate.
  logic [laers_pkg::LOSS_W-1:0] loss_hist [HIST_DEPTH];
  logic [3:0]                   hist_wr_ptr;
  logic [4:0]                   hist_count;
  logic [10:0]                  hist_sum;
  logic [laers_pkg::ACC_W-1:0]  rtx_bytes_acc;
  logic [34:0]                  rtx_bps_last;

  split_t expected_split [$];

  function automatic split_t split_for(input logic [laers_pkg::BW_W-1:0] bw);
    int                unsigned prot;
    longint            unsigned rtx_kbps;
    longint            unsigned headroom;
    split_t            res;
    prot = 0;
    if (hist_count != 0) begin
      prot = (int'(hist_sum) / int'(hist_count)) * 2;
    end
    if (prot > laers_pkg::PROT_CAP) begin
      prot = laers_pkg::PROT_CAP;
    end
    rtx_kbps = longint'(rtx_bps_last) / 1000;
    headroom = (longint'(bw) > rtx_kbps) ? longint'(bw) - rtx_kbps : 0;
    res.protection_pct = laers_pkg::PROT_W'(prot);
    res.target_kbps    = laers_pkg::ENC_W'(headroom * (laers_pkg::PCT_SCALE - prot)
                                           / laers_pkg::PCT_SCALE);
    return res;
  endfunction

  task automatic take_request(input logic [1:0] cmd, input logic [47:0] data);
    logic [laers_pkg::LOSS_W-1:0] loss;
    logic [laers_pkg::RTX_W-1:0]  bytes;
    logic [laers_pkg::BW_W-1:0]   bw;
    logic [laers_pkg::ACC_W:0]    acc_sum;
    loss  = data[6:0];
    bytes = data[22:7];
    bw    = data[42:23];
    case (cmd)
      laers_pkg::CMD_LOSS: begin
        // Once the window is full the oldest entry drops out of the sum.
        if (hist_count == HIST_DEPTH) begin
          hist_sum = hist_sum - loss_hist[hist_wr_ptr];
        end else begin
          hist_count = hist_count + 1'b1;
        end
        loss_hist[hist_wr_ptr] = loss;
        hist_sum    = hist_sum + loss;
        hist_wr_ptr = hist_wr_ptr + 1'b1;
      end
      laers_pkg::CMD_RTX: begin
        acc_sum       = {1'b0, rtx_bytes_acc} + bytes;
        rtx_bytes_acc = acc_sum[laers_pkg::ACC_W] ? '1 : acc_sum[laers_pkg::ACC_W-1:0];
      end
      laers_pkg::CMD_TICK: begin
        rtx_bps_last  = {rtx_bytes_acc, 3'b000};
        rtx_bytes_acc = '0;
      end
      laers_pkg::CMD_BW: begin
        expected_split = {expected_split, split_for(bw)};
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input logic [31:0] word);
    split_t got;
    split_t want;
    got.protection_pct = word[5:0];
    got.target_kbps    = word[25:6];
    results_seen++;
    if (expected_split.size() == 0) begin
      if (mismatches < 10) begin
        $display("%t: unexpected result prot=%0d enc=%0d", $realtime, got.protection_pct,
                 got.target_kbps);
      end
      mismatches++;
    end else begin
      want = expected_split[0];
      expected_split.delete(0);
      if (got.protection_pct != want.protection_pct || got.target_kbps != want.target_kbps)
      begin
        if (mismatches < 10) begin
          $display("%t: result %0d: prot exp %0d got %0d, enc exp %0d got %0d", $realtime,
                   results_seen, want.protection_pct, got.protection_pct,
                   want.target_kbps, got.target_kbps);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hist_wr_ptr   = '0;
      hist_count    = '0;
      hist_sum      = '0;
      rtx_bytes_acc = '0;
      rtx_bps_last  = '0;
      expected_split.delete();
      mismatches    = 0;
      results_seen  = 0;
    end else begin
      // A result can never stem from a request taken at the same edge.
      if (m_tvalid && m_tready) begin
        check_result(m_tdata);
      end
      if (s_tvalid && s_tready) begin
        take_request(s_tuser, s_tdata);
      end
    end
    outstanding = expected_split.size();
  end

endmodule

/* verif/loss_aware_encoder_rate_split_test.sv */
`timescale 1ns / 1ps

module loss_aware_encoder_rate_split_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // s_tdata, from bit 0: loss_pct[6:0], rtx_bytes[15:0], bandwidth_kbps[19:0], zero fill
  logic [47:0] s_tdata = '0;
  // s_tuser: command[1:0]
  logic [1:0]  s_tuser = laers_pkg::CMD_LOSS;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // m_tdata, from bit 0: protection_pct[5:0], target_kbps[19:0], zero fill
  logic [31:0] m_tdata;

  // Percentages of cycles in which the sender stays idle and the receiver stalls.
  int idle_pct  = 0;
  int stall_pct = 0;
  // The long output hold-off is asked for by the stimulus and timed by the receiver.
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;
  // Upper bound of the loss reports; it moves now and then so that the protection
  // figure wanders below the cap as well as sitting on it.
  int loss_ceiling = 100;
  int sent [4];

  int mismatches;
  int outstanding;
  int results_seen;

  initial begin
    forever #5 clk = ~clk;
  end

  loss_aware_encoder_rate_split i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  laers_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  // Hard limit. The slowest correct run, with every request a bandwidth update under the
  // heaviest stalls, stays well under a fifth of this.
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver. It stalls at the rate of the current phase, and once in the run it holds
  // off while the sender keeps offering requests, so that the block backs up and has
  // to refuse input.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  // Offers one request, called and returning at a rising edge. Ready is looked at on
  // the falling edge, where it is settled, and the request is taken at the next rising
  // edge. Random idle cycles go in front of the request at the phase's rate.
  task automatic send_request(input logic [1:0] cmd, input logic [6:0] loss,
                              input logic [15:0] bytes, input logic [19:0] bw);
    if ($urandom_range(1, 100) <= idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(1, 100) <= idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'b0, bw, bytes, loss};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    sent[cmd]++;
  endtask

  // Holds the sender back until every expected result has come out.
  task automatic drain;
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // One random request. Fields that the command does not use carry random noise.
  task automatic send_random;
    logic [1:0]  cmd;
    logic [6:0]  loss;
    logic [15:0] bytes;
    logic [19:0] bw;
    int          pick;
    if ($urandom_range(0, 31) == 0) begin
      case ($urandom_range(0, 5))
        0:       loss_ceiling = 0;
        1:       loss_ceiling = 6;
        2:       loss_ceiling = 20;
        3:       loss_ceiling = 50;
        4:       loss_ceiling = 100;
        default: loss_ceiling = 127;
      endcase
    end
    pick  = $urandom_range(0, 99);
    cmd   = (pick < 30) ? laers_pkg::CMD_LOSS : (pick < 55) ? laers_pkg::CMD_RTX :
            (pick < 65) ? laers_pkg::CMD_TICK : laers_pkg::CMD_BW;
    loss  = 7'($urandom);
    bytes = 16'($urandom);
    bw    = 20'($urandom);
    case (cmd)
      laers_pkg::CMD_LOSS: loss = 7'($urandom_range(0, loss_ceiling));
      laers_pkg::CMD_RTX: begin
        // Mostly packet-sized retransmissions, now and then anything up to the maximum.
        if ($urandom_range(0, 3) != 0) begin
          bytes = 16'($urandom_range(40, 1500));
        end
      end
      laers_pkg::CMD_BW: begin
        // Low bandwidths meet the retransmit rate; the rest spread over all magnitudes.
        if ($urandom_range(0, 2) == 0) begin
          bw = 20'($urandom_range(0, 3000));
        end else begin
          bw = 20'($urandom >> $urandom_range(12, 31));
        end
      end
      default: ;
    endcase
    send_request(cmd, loss, bytes, bw);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests. An empty window gives no protection, at zero and full bandwidth.
    send_request(laers_pkg::CMD_BW, '0, '0, 20'd1000);
    send_request(laers_pkg::CMD_BW, '0, '0, '0);
    send_request(laers_pkg::CMD_BW, '0, '0, '1);
    // Loss at both ends of the range, then a loss above one hundred; the cap holds.
    send_request(laers_pkg::CMD_LOSS, 7'd0, '1, '1);
    send_request(laers_pkg::CMD_LOSS, 7'd100, '0, '0);
    send_request(laers_pkg::CMD_BW, '1, '1, 20'd999);
    send_request(laers_pkg::CMD_LOSS, 7'd127, '0, '0);
    send_request(laers_pkg::CMD_BW, '0, '0, '1);
    // Largest and empty retransmissions, a tick, then bandwidth above and below the
    // retransmit rate.
    send_request(laers_pkg::CMD_RTX, '1, 16'hFFFF, '1);
    send_request(laers_pkg::CMD_RTX, '0, 16'h0000, '0);
    send_request(laers_pkg::CMD_TICK, '1, '1, '1);
    send_request(laers_pkg::CMD_BW, '0, '0, '1);
    send_request(laers_pkg::CMD_BW, '0, '0, 20'd100);
    send_request(laers_pkg::CMD_TICK, '0, '0, '0);
    send_request(laers_pkg::CMD_BW, '0, '0, 20'd1);

    // A small retransmission, ticks around it and bandwidth updates at both ends.
    send_request(laers_pkg::CMD_RTX, '0, 16'd1, '0);
    send_request(laers_pkg::CMD_TICK, '0, '0, '0);
    send_request(laers_pkg::CMD_BW, '0, '0, '1);
    send_request(laers_pkg::CMD_BW, '0, '0, '0);
    send_request(laers_pkg::CMD_TICK, '0, '0, '0);
    send_request(laers_pkg::CMD_BW, '0, '0, 20'd5000);
    drain;

    // Random requests in four handshake mixes; the sender waits for all results at the
    // end of each one.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          long_hold_req = 1'b1;
        end
        1: begin
          idle_pct  = 81;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 81;
        end
        default: begin
          idle_pct  = 10;
          stall_pct = 10;
        end
      endcase
      repeat (232) send_random();
      drain;
    end

    // Let any request that gives no result finish inside the block.
    repeat (60) @(posedge clk);

    $display("Covered %0d loss reports, %0d retransmit reports, %0d ticks and %0d bandwidth",
             sent[laers_pkg::CMD_LOSS], sent[laers_pkg::CMD_RTX], sent[laers_pkg::CMD_TICK],
             sent[laers_pkg::CMD_BW]);
    $display("updates, %0d results checked, with a long output hold-off and drained pauses.",
             results_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/laers_pkg.sv
hw/rtl/laers_ram.sv
hw/rtl/laers_div.sv
hw/rtl/loss_aware_encoder_rate_split.sv
verif/laers_checker.sv
verif/loss_aware_encoder_rate_split_test.sv
